// ----- rtl/quaternion_to_rotation_matrix_unit_defines.svh -----
// Assertion macros shared by the checkers of the quaternion to matrix unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QRM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qrm_pkg.sv -----
package qrm_pkg;

  // Width of a matrix element before rounding, in Q2.30 with headroom.
  localparam int unsigned ElemW = 35;
  // Number of fraction bits dropped when going from Q2.30 to Q2.14.
  localparam int unsigned DropW = 16;
  // Width of the rounded element before saturation.
  localparam int unsigned RndW = ElemW - DropW;
  // Number of matrix elements.
  localparam int unsigned NumElem = 9;

  // 1.0 in Q2.30 and the half-LSB bias used for rounding.
  localparam logic signed [ElemW-1:0] OneQ30    = ElemW'(64'sd1 <<< 30);
  localparam logic signed [ElemW-1:0] RoundHalf = ElemW'(64'sd1 <<< (DropW - 1));

  // Saturation bounds of a Q2.14 element.
  localparam logic signed [RndW-1:0] MaxQ214 = RndW'(32767);
  localparam logic signed [RndW-1:0] MinQ214 = -RndW'(32768);

  // One quaternion, signed Q1.15 components.
  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } quat_in_t;

  // One rotation matrix, signed Q2.14 elements, row-major.
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               saturated;
  } mat_out_t;

  // Pairwise component products, exact Q2.30.
  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    logic signed [31:0] xz;
    logic signed [31:0] xw;
    logic signed [31:0] yy;
    logic signed [31:0] yz;
    logic signed [31:0] yw;
    logic signed [31:0] zz;
    logic signed [31:0] zw;
  } prod_t;

  // Unrounded matrix elements in Q2.30, row-major, element 0 in the low slot.
  typedef struct packed {
    logic [NumElem-1:0][ElemW-1:0] e;
  } elem_t;

endpackage

// ----- rtl/qrm_mult.sv -----
// First stage: forms the nine pairwise products of the quaternion components.
module qrm_mult (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  qrm_pkg::quat_in_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output qrm_pkg::prod_t    data_o
);

  logic           valid_q;
  qrm_pkg::prod_t data_q;
  qrm_pkg::prod_t data_d;

  // The stage takes a new transfer when empty or when its content moves on.
  assign ready_o = !valid_q || ready_i;

  // Sign-extended operands give exact 32-bit products.
  always_comb begin
    data_d.xx = 32'(data_i.quat_x) * 32'(data_i.quat_x);
    data_d.xy = 32'(data_i.quat_x) * 32'(data_i.quat_y);
    data_d.xz = 32'(data_i.quat_x) * 32'(data_i.quat_z);
    data_d.xw = 32'(data_i.quat_x) * 32'(data_i.quat_w);
    data_d.yy = 32'(data_i.quat_y) * 32'(data_i.quat_y);
    data_d.yz = 32'(data_i.quat_y) * 32'(data_i.quat_z);
    data_d.yw = 32'(data_i.quat_y) * 32'(data_i.quat_w);
    data_d.zz = 32'(data_i.quat_z) * 32'(data_i.quat_z);
    data_d.zw = 32'(data_i.quat_z) * 32'(data_i.quat_w);
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Product register, loaded only on an incoming transfer.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/qrm_comb.sv -----
// Second stage: combines the products into the nine unrounded elements.
module qrm_comb (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  qrm_pkg::prod_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output qrm_pkg::elem_t data_o
);

  logic           valid_q;
  qrm_pkg::elem_t data_q;
  qrm_pkg::elem_t data_d;

  logic signed [qrm_pkg::ElemW-1:0] xx, xy, xz, xw, yy, yz, yw, zz, zw;

  assign ready_o = !valid_q || ready_i;

  // Products widened to element width so that the sums cannot overflow.
  assign xx = qrm_pkg::ElemW'(data_i.xx);
  assign xy = qrm_pkg::ElemW'(data_i.xy);
  assign xz = qrm_pkg::ElemW'(data_i.xz);
  assign xw = qrm_pkg::ElemW'(data_i.xw);
  assign yy = qrm_pkg::ElemW'(data_i.yy);
  assign yz = qrm_pkg::ElemW'(data_i.yz);
  assign yw = qrm_pkg::ElemW'(data_i.yw);
  assign zz = qrm_pkg::ElemW'(data_i.zz);
  assign zw = qrm_pkg::ElemW'(data_i.zw);

  // Diagonal elements are 1 - 2(a+b), the others 2(a+-b).
  always_comb begin
    data_d.e[0] = qrm_pkg::OneQ30 - ((yy + zz) <<< 1);
    data_d.e[1] = (xy + zw) <<< 1;
    data_d.e[2] = (xz - yw) <<< 1;
    data_d.e[3] = (xy - zw) <<< 1;
    data_d.e[4] = qrm_pkg::OneQ30 - ((xx + zz) <<< 1);
    data_d.e[5] = (yz + xw) <<< 1;
    data_d.e[6] = (xz + yw) <<< 1;
    data_d.e[7] = (yz - xw) <<< 1;
    data_d.e[8] = qrm_pkg::OneQ30 - ((xx + yy) <<< 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/qrm_round.sv -----
// Third stage: rounds each element to Q2.14, saturates it and holds the
// result in the output register.
module qrm_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  qrm_pkg::elem_t    data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output qrm_pkg::mat_out_t data_o
);

  logic                          valid_q;
  qrm_pkg::mat_out_t             data_q;
  qrm_pkg::mat_out_t             data_d;
  logic [qrm_pkg::NumElem-1:0]   sat;
  logic [qrm_pkg::NumElem-1:0][15:0] res;

  logic signed [qrm_pkg::ElemW-1:0] biased [qrm_pkg::NumElem];
  logic signed [qrm_pkg::RndW-1:0]  rnd    [qrm_pkg::NumElem];

  assign ready_o = !valid_q || ready_i;

  // Round half up by adding half an LSB and dropping the low bits, then clamp.
  always_comb begin
    for (int i = 0; i < qrm_pkg::NumElem; i++) begin
      biased[i] = $signed(data_i.e[i]) + qrm_pkg::RoundHalf;
      rnd[i]    = biased[i][qrm_pkg::ElemW-1:qrm_pkg::DropW];
      if (rnd[i] > qrm_pkg::MaxQ214) begin
        res[i] = 16'(qrm_pkg::MaxQ214);
        sat[i] = 1'b1;
      end else if (rnd[i] < qrm_pkg::MinQ214) begin
        res[i] = 16'(qrm_pkg::MinQ214);
        sat[i] = 1'b1;
      end else begin
        res[i] = 16'(rnd[i]);
        sat[i] = 1'b0;
      end
    end
  end

  // Map the row-major slots onto the named result fields.
  always_comb begin
    data_d.m00       = res[0];
    data_d.m01       = res[1];
    data_d.m02       = res[2];
    data_d.m10       = res[3];
    data_d.m11       = res[4];
    data_d.m12       = res[5];
    data_d.m20       = res[6];
    data_d.m21       = res[7];
    data_d.m22       = res[8];
    data_d.saturated = |sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/quaternion_to_rotation_matrix_unit.sv -----
// Quaternion to rotation matrix unit.
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one quaternion
// per transfer, components x, y, z, w in signed Q1.15; it need not be normalized.
// The output channel (out_valid_o, out_ready_i, out_data_o) carries the 3x3
// matrix in row-major order in signed Q2.14, rounded half up, plus a flag
// that is set when any element was clamped to the Q2.14 range.
// The unit is a three-stage pipeline: products, element sums, then rounding
// into the output register. A quaternion passes the product, element and
// output registers in that order before its matrix shows on the output port.
// Throughput is one quaternion per cycle while the receiver takes results;
// each stage takes a new transfer whenever it is empty or its content moves
// on in the same cycle.
// When the receiver stalls, the result holds on the output port and the
// stages behind it fill up; in_ready_o drops only once all three are full.
// Reset empties the pipeline; out_valid_o is low until a new result arrives.
// No state carries over from one quaternion to the next.
module quaternion_to_rotation_matrix_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qrm_pkg::quat_in_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qrm_pkg::mat_out_t out_data_o
);

  logic           prod_valid;
  logic           prod_ready;
  qrm_pkg::prod_t prod_data;
  logic           elem_valid;
  logic           elem_ready;
  qrm_pkg::elem_t elem_data;

  // Stage one: component products.
  qrm_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  // Stage two: unrounded elements.
  qrm_comb u_comb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod_data),
    .valid_o (elem_valid),
    .ready_i (elem_ready),
    .data_o  (elem_data)
  );

  // Stage three: rounding, saturation and output register.
  qrm_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (elem_valid),
    .ready_o (elem_ready),
    .data_i  (elem_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

// ----- rtl/qrm_checker.sv -----
`include "quaternion_to_rotation_matrix_unit_defines.svh"

// Port-level checks of the quaternion to matrix unit.
module qrm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input qrm_pkg::mat_out_t out_data_i
);

  logic out_stall;
  logic diag_ok;

  // A result is waiting on the port and the receiver does not take it.
  assign out_stall = out_valid_i && !out_ready_i;

  // A diagonal element is 1 - 2(a+b) with a, b >= 0, so it never exceeds 1.0.
  assign diag_ok = (out_data_i.m00 <= 16'sd16384) && (out_data_i.m11 <= 16'sd16384) &&
                   (out_data_i.m22 <= 16'sd16384);

  // A stalled result stays on the port.
  `QRM_ASSERT_NEXT(a_out_valid_hold, out_stall, out_valid_i, "result dropped while stalled")

  `QRM_ASSERT_NEXT(a_out_data_hold, out_stall, $stable(out_data_i), "result changed while stalled")

  // Back pressure reaches the input only when the output is full and stalled.
  `QRM_ASSERT_SAME(a_ready_backpressure, !in_ready_i, out_stall, "input stalled with room")

  `QRM_ASSERT_SAME(a_diag_bound, out_valid_i, diag_ok, "diagonal element above 1.0")

endmodule

bind quaternion_to_rotation_matrix_unit qrm_checker u_qrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ----- tb/sv/quaternion_to_rotation_matrix_unit_tb.sv -----
module quaternion_to_rotation_matrix_unit_tb;

  localparam int RandomItems = 1530;
  // Boundaries of the idling phases, in transfers on each side.
  localparam int PhaseOneEnd = 520;
  localparam int PhaseTwoEnd = 1040;
  // The receiver stops for a long stretch once this many matrices came out.
  localparam int HoldAt = 1150;
  localparam int HoldCycles = 60;
  // The sender waits for the pipeline to run dry after this many transfers.
  localparam int DrainAt = 1300;
  localparam longint OneQ30 = 64'sd1 <<< 30;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  qrm_pkg::quat_in_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  qrm_pkg::mat_out_t  out_data;

  qrm_pkg::quat_in_t  quat_pending [$];
  qrm_pkg::mat_out_t  mat_expected [$];
  int                 quats_sent = 0;
  int                 mismatches = 0;

  quaternion_to_rotation_matrix_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Free-running clock, period 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Exact matrix of one quaternion: Q2.30 elements, rounded half up to Q2.14
  // and clamped, with the flag raised on any clamp.
  function automatic qrm_pkg::mat_out_t rotate_quat(input qrm_pkg::quat_in_t q);
    longint            x, y, z, w;
    longint            elem [9];
    longint            r;
    logic [15:0]       m [9];
    qrm_pkg::mat_out_t res;
    x = $signed(q.quat_x);
    y = $signed(q.quat_y);
    z = $signed(q.quat_z);
    w = $signed(q.quat_w);
    elem[0] = OneQ30 - 2 * (y * y + z * z);
    elem[1] = 2 * (x * y + z * w);
    elem[2] = 2 * (x * z - y * w);
    elem[3] = 2 * (x * y - z * w);
    elem[4] = OneQ30 - 2 * (x * x + z * z);
    elem[5] = 2 * (y * z + x * w);
    elem[6] = 2 * (x * z + y * w);
    elem[7] = 2 * (y * z - x * w);
    elem[8] = OneQ30 - 2 * (x * x + y * y);
    res = '0;
    for (int i = 0; i < 9; i++) begin
      r = (elem[i] + 64'sd32768) >>> 16;
      if (r > 32767) begin
        r = 32767;
        res.saturated = 1'b1;
      end else if (r < -32768) begin
        r = -32768;
        res.saturated = 1'b1;
      end
      m[i] = r[15:0];
    end
    res.m00 = m[0];
    res.m01 = m[1];
    res.m02 = m[2];
    res.m10 = m[3];
    res.m11 = m[4];
    res.m12 = m[5];
    res.m20 = m[6];
    res.m21 = m[7];
    res.m22 = m[8];
    return res;
  endfunction

  task automatic queue_quat(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input logic [15:0] w);
    qrm_pkg::quat_in_t q;
    q.quat_x = x;
    q.quat_y = y;
    q.quat_z = z;
    q.quat_w = w;
    quat_pending = {quat_pending, q};
  endtask

  task automatic check_elem(input string tag, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, tag, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Sender: offers queued quaternions and records the matrix each transfer
  // should produce.
  always @(posedge clk or negedge rst_n) begin : drive_quat
    bit offer;
    bit holding;
    int idle_pct;
    bit drained;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        mat_expected = {mat_expected, rotate_quat(in_data)};
        quats_sent++;
      end
      if (!holding) begin
        if (quats_sent < PhaseOneEnd) idle_pct = 28;
        else if (quats_sent < PhaseTwoEnd) idle_pct = 69;
        else idle_pct = 0;
        offer = quat_pending.size() != 0 && $urandom_range(99) >= idle_pct;
        // Pause once until every outstanding matrix has come out.
        if (quats_sent == DrainAt && !drained) begin
          if (mat_expected.size() == 0) drained = 1'b1;
          else offer = 1'b0;
        end
        if (offer) begin
          in_data <= quat_pending.pop_front();
        end
        in_valid <= offer;
      end
    end
  end

  // Receiver: checks each matrix transfer against the oldest prediction.
  always @(posedge clk or negedge rst_n) begin : check_mat
    qrm_pkg::mat_out_t want;
    int                mats_seen;
    int                hold_left;
    bit                held;
    int                stall_pct;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (mat_expected.size() == 0) begin
          $display("%0t: matrix with no quaternion pending, expected none, actual %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = mat_expected.pop_front();
          check_elem("m00", want.m00, out_data.m00);
          check_elem("m01", want.m01, out_data.m01);
          check_elem("m02", want.m02, out_data.m02);
          check_elem("m10", want.m10, out_data.m10);
          check_elem("m11", want.m11, out_data.m11);
          check_elem("m12", want.m12, out_data.m12);
          check_elem("m20", want.m20, out_data.m20);
          check_elem("m21", want.m21, out_data.m21);
          check_elem("m22", want.m22, out_data.m22);
          check_elem("saturated", {15'b0, want.saturated}, {15'b0, out_data.saturated});
        end
        mats_seen++;
      end
      // One long hold-off so the pipeline fills and stalls its input.
      if (!held && mats_seen >= HoldAt) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      if (mats_seen < PhaseOneEnd) stall_pct = 69;
      else if (mats_seen < PhaseTwoEnd) stall_pct = 28;
      else stall_pct = 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= stall_pct;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int          kind;
    real         norm;
    real         comp_r [4];
    logic [15:0] comp [4];

    // Zero, identity and full-scale corners; all at -1.0 saturates.
    queue_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    queue_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    queue_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    // Each component alone at its extremes.
    queue_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
    queue_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    queue_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd0);
    queue_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
    queue_quat(16'sd0, 16'sd0, -16'sd32768, 16'sd0);
    queue_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0);
    queue_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768);
    queue_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    // Alternating extremes.
    queue_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    queue_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    // Quarter turns about each axis and the half-half case.
    queue_quat(16'sd23170, 16'sd0, 16'sd0, 16'sd23170);
    queue_quat(16'sd0, 16'sd23170, 16'sd0, 16'sd23170);
    queue_quat(16'sd0, 16'sd0, 16'sd23170, 16'sd23170);
    queue_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    // Off-diagonal exactly half an LSB, positive and negative.
    queue_quat(16'sd128, 16'sd128, 16'sd0, 16'sd0);
    queue_quat(16'sd128, -16'sd128, 16'sd0, 16'sd0);

    for (int n = 0; n < RandomItems; n++) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        // Unit quaternion in a random direction.
        norm = 0.0;
        for (int k = 0; k < 4; k++) begin
          comp_r[k] = real'(int'($urandom_range(65535)) - 32768);
          norm += comp_r[k] * comp_r[k];
        end
        if (norm == 0.0) begin
          comp_r[3] = 1.0;
          norm = 1.0;
        end
        norm = 32767.0 / $sqrt(norm);
        for (int k = 0; k < 4; k++) comp[k] = 16'($rtoi(comp_r[k] * norm));
      end else if (kind < 80) begin
        for (int k = 0; k < 4; k++) comp[k] = 16'($urandom);
      end else begin
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(5))
            0: comp[k] = 16'h8000;
            1: comp[k] = 16'h7fff;
            2: comp[k] = 16'h0000;
            3: comp[k] = 16'hffff;
            4: comp[k] = 16'h0001;
            default: comp[k] = 16'($urandom);
          endcase
        end
      end
      queue_quat(comp[0], comp[1], comp[2], comp[3]);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (quat_pending.size() != 0 || in_valid) @(posedge clk);
    while (mat_expected.size() != 0) @(posedge clk);
    // A few more cycles to catch any extra matrix.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/qrm_pkg.sv
rtl/qrm_mult.sv
rtl/qrm_comb.sv
rtl/qrm_round.sv
rtl/quaternion_to_rotation_matrix_unit.sv
rtl/qrm_checker.sv
tb/sv/quaternion_to_rotation_matrix_unit_tb.sv
